>>> src/sbvr_pkg.sv
// sbvr_pkg: shared types and constants for the square-root braking velocity ramp
// holds the configuration register indexes and the sequencer state encoding
// no dependencies
`default_nettype none

package sbvr_pkg;

    // configuration register index width and register indexes
    localparam int CFG_INDEX_WIDTH = 3;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LIN_MAX = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LIN_MIN = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LIN_ACC = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ANG_MAX = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ANG_MIN = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ANG_ACC = 3'd5;

    // axis selector codes
    localparam logic AXIS_LINEAR  = 1'b0;
    localparam logic AXIS_ANGULAR = 1'b1;

    // sequencer states, one-hot
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_SQRT = 6'b000100,
        S_TGT  = 6'b001000,
        S_DIFF = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

endpackage

`default_nettype wire

>>> src/sqrt_braking_velocity_ramp_top.sv
// sqrt_braking_velocity_ramp_top: two-axis velocity ramp with square-root braking target
// bit-serial multipliers and a bit-serial restoring square root, one bit per cycle
// depends on sbvr_pkg
//
// usage:
//   input channel (i_in_valid / o_in_stall) carries one word: axis select, error,
//   reverse flag and elapsed time. output channel (o_out_valid / i_out_stall)
//   returns one word per input word: the new axis velocity and a clamp flag.
//   configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_data);
//   indexes above the last register are ignored. write only while idle.
// timing:
//   one word is worked on at a time. two shift-add multipliers run together
//   (accel * |error| and accel * elapsed), then the restoring square root forms
//   the root one bit at a time; the S_TGT, S_DIFF and S_DONE states then form the
//   target, ramp step and difference, then the ramp, then the clamp.
// reset: synchronous, active low; both kept velocities clear to zero and the
//   configuration registers take their default values.
// stall: a finished word sits in the output register; the next input word is
//   still taken and worked on, and only its final clamp step waits for the
//   output register to drain.
`default_nettype none

module sqrt_braking_velocity_ramp_top
    import sbvr_pkg::*;
#(
    parameter int VALUE_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // input channel
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic                        i_cmd,
    input  wire logic signed [VALUE_WIDTH-1:0] i_error,
    input  wire logic                        i_reverse,
    input  wire logic        [VALUE_WIDTH-1:0] i_elapsed,
    // output channel
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic signed [VALUE_WIDTH-1:0]    o_velocity,
    output logic                             o_clamped,
    // configuration write port
    input  wire logic                        i_cfg_we,
    input  wire logic [CFG_INDEX_WIDTH-1:0]  i_cfg_index,
    input  wire logic [VALUE_WIDTH-1:0]      i_cfg_data
);

    localparam int W   = VALUE_WIDTH;
    localparam int F   = FRACTION_BITS;
    localparam int CW  = $clog2(W);
    localparam int PW  = 2 * W + F;
    localparam logic [CW-1:0] LAST_BIT = CW'(W - 1);
    localparam logic signed [W-1:0] VMAXPOS = {1'b0, {(W-1){1'b1}}};

    // configuration registers
    logic signed [W-1:0] r_lin_max, r_lin_min, r_ang_max, r_ang_min;
    logic        [W-2:0] r_lin_acc, r_ang_acc;

    // kept axis velocities
    logic signed [W-1:0] r_lin_vel, r_ang_vel;

    // sequencer
    t_state              r_state, n_state;
    logic [CW-1:0]       r_cnt;
    logic                r_out_valid;

    // datapath
    logic        [2*W-1:0] r_pm;     // error product, then radicand shift register
    logic        [2*W-1:0] r_ps;     // step product
    logic        [W-2:0]   r_acc;
    logic        [W:0]     r_rem;
    logic        [W-1:0]   r_root;
    logic                  r_axis;
    logic                  r_neg;
    logic signed [W-1:0]   r_target;
    logic        [W-2:0]   r_step;
    logic signed [W:0]     r_diff;
    logic signed [W-1:0]   r_vel;
    logic signed [W-1:0]   r_velocity;
    logic                  r_clamped;

    logic in_acc, out_acc, done_go;
    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = r_out_valid && !i_out_stall;
    assign done_go = (r_state == S_DONE) && !(r_out_valid && i_out_stall);

    // magnitude of the incoming error, most negative maps to 2^(W-1)
    logic [W-1:0] mag;
    assign mag = i_error[W-1] ? (~i_error + W'(1)) : i_error;

    // shift-add multiplier steps, one multiplier bit per cycle
    logic [W:0] pm_sum, ps_sum;
    logic [2*W-1:0] pm_next;
    assign pm_sum  = {1'b0, r_pm[2*W-1:W]} + (r_pm[0] ? {2'b00, r_acc} : '0);
    assign ps_sum  = {1'b0, r_ps[2*W-1:W]} + (r_ps[0] ? {2'b00, r_acc} : '0);
    assign pm_next = {pm_sum, r_pm[W-1:1]};

    // restoring square root step, two radicand bits in, one root bit out
    logic [W+1:0] rem_sh, trial;
    logic [W+2:0] sq_sub;
    logic         sq_fit;
    assign rem_sh = {r_rem[W-1:0], r_pm[2*W-1:2*W-2]};
    assign trial  = {r_root, 2'b01};
    assign sq_sub = {1'b0, rem_sh} - {1'b0, trial};
    assign sq_fit = !sq_sub[W+2];

    // target: saturate root, then apply direction
    logic signed [W-1:0] root_sat, target;
    assign root_sat = r_root[W-1] ? VMAXPOS : r_root;
    assign target   = r_neg ? -root_sat : root_sat;

    // ramp step: product scaled down, saturated to the largest positive value
    logic [PW-1:0] ps_ext;
    logic          step_sat;
    assign ps_ext   = {{F{1'b0}}, r_ps};
    assign step_sat = |ps_ext[PW-1:F+W-1];

    // kept velocity and limits of the selected axis
    logic signed [W-1:0] cur, vmax, vmin;
    assign cur  = (r_axis == AXIS_ANGULAR) ? r_ang_vel : r_lin_vel;
    assign vmax = (r_axis == AXIS_ANGULAR) ? r_ang_max : r_lin_max;
    assign vmin = (r_axis == AXIS_ANGULAR) ? r_ang_min : r_lin_min;

    // ramp toward target by at most one step
    logic signed [W:0]   cur_ext, tgt_ext, step_ext, up_sum, dn_sum, diff_sum;
    logic                take_up, take_dn;
    logic signed [W-1:0] ramp_vel;
    assign cur_ext  = {cur[W-1], cur};
    assign tgt_ext  = {target[W-1], target};
    assign step_ext = {2'b00, r_step};
    assign up_sum   = cur_ext + step_ext;
    assign dn_sum   = cur_ext - step_ext;
    assign diff_sum = r_diff + step_ext;
    assign take_up  = r_diff < step_ext;
    assign take_dn  = diff_sum > 0;
    always_comb begin
        if (r_diff > 0) begin
            ramp_vel = take_up ? r_target : up_sum[W-1:0];
        end else begin
            ramp_vel = take_dn ? r_target : dn_sum[W-1:0];
        end
    end

    // clamp, max first
    logic signed [W-1:0] clamp_vel;
    logic                clamp_hit;
    always_comb begin
        if (r_vel > vmax) begin
            clamp_vel = vmax;
            clamp_hit = 1'b1;
        end else if (r_vel < vmin) begin
            clamp_vel = vmin;
            clamp_hit = 1'b1;
        end else begin
            clamp_vel = r_vel;
            clamp_hit = 1'b0;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (in_acc) begin
                n_state = S_MUL;
            end
            S_MUL: if (r_cnt == LAST_BIT) begin
                n_state = S_SQRT;
            end
            S_SQRT: if (r_cnt == LAST_BIT) begin
                n_state = S_TGT;
            end
            S_TGT:  n_state = S_DIFF;
            S_DIFF: n_state = S_DONE;
            S_DONE: if (done_go) begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_MUL || r_state == S_SQRT) begin
                r_cnt <= (r_cnt == LAST_BIT) ? '0 : r_cnt + CW'(1);
            end else begin
                r_cnt <= '0;
            end
            if (done_go) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // configuration registers and kept velocities
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lin_max <= W'(1) <<< (F - 1);
            r_lin_min <= '0;
            r_lin_acc <= (W-1)'(1) << (F - 1);
            r_ang_max <= W'(1) <<< F;
            r_ang_min <= -(W'(1) <<< F);
            r_ang_acc <= (W-1)'(1) << F;
            r_lin_vel <= '0;
            r_ang_vel <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_LIN_MAX: r_lin_max <= i_cfg_data;
                    CFG_LIN_MIN: r_lin_min <= i_cfg_data;
                    CFG_LIN_ACC: r_lin_acc <= i_cfg_data[W-2:0];
                    CFG_ANG_MAX: r_ang_max <= i_cfg_data;
                    CFG_ANG_MIN: r_ang_min <= i_cfg_data;
                    CFG_ANG_ACC: r_ang_acc <= i_cfg_data[W-2:0];
                    default: ;
                endcase
            end
            if (done_go) begin
                if (r_axis == AXIS_ANGULAR) begin
                    r_ang_vel <= clamp_vel;
                end else begin
                    r_lin_vel <= clamp_vel;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: if (in_acc) begin
                r_axis <= i_cmd;
                r_neg  <= i_cmd ? i_error[W-1] : i_reverse;
                r_acc  <= i_cmd ? r_ang_acc : r_lin_acc;
                r_pm   <= {{W{1'b0}}, mag};
                r_ps   <= {{W{1'b0}}, i_elapsed};
            end
            S_MUL: begin
                r_ps <= {ps_sum, r_ps[W-1:1]};
                if (r_cnt == LAST_BIT) begin
                    // radicand is twice the product
                    r_pm <= {pm_next[2*W-2:0], 1'b0};
                end else begin
                    r_pm <= pm_next;
                end
                r_rem  <= '0;
                r_root <= '0;
            end
            S_SQRT: begin
                r_pm   <= {r_pm[2*W-3:0], 2'b00};
                r_rem  <= sq_fit ? sq_sub[W:0] : rem_sh[W:0];
                r_root <= {r_root[W-2:0], sq_fit};
            end
            S_TGT: begin
                r_target <= target;
                r_step   <= step_sat ? {(W-1){1'b1}} : ps_ext[F+W-2:F];
                r_diff   <= tgt_ext - cur_ext;
            end
            S_DIFF: begin
                r_vel <= ramp_vel;
            end
            default: ;
        endcase
        if (done_go) begin
            r_velocity <= clamp_vel;
            r_clamped  <= clamp_hit;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_velocity  = r_velocity;
    assign o_clamped   = r_clamped;

`ifndef NO_ASSERTIONS
    // the multiply phase runs its full bit count before moving on
    a_mul_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL && r_cnt != LAST_BIT) |=> (r_state == S_MUL))
        else $error("multiply phase left early");

    // ramped velocity lies between the kept velocity and the target
    a_ramp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |->
            ((r_vel >= cur && r_vel <= r_target) || (r_vel <= cur && r_vel >= r_target)))
        else $error("ramp overshoot");

    // a delivered word matches the kept velocity of its axis
    a_state_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done_go |=> (o_velocity == cur))
        else $error("kept velocity differs from output");

    // output valid only rises after the clamp step
    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("output valid without a finished word");
`endif

endmodule

`default_nettype wire
